@@ rtl/mdc_pkg.sv @@
package mdc_pkg;

    localparam int OP_W       = 3;
    localparam int CURRENT_W  = 16;
    localparam int DUTY_W     = 8;
    localparam int MS_W       = 20;
    localparam int STATE_W    = 4;
    localparam int CAUSE_W    = 2;
    localparam int COUNT_W    = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;

    localparam int QUEUE_DEPTH_DEF = 2;

    typedef logic [DUTY_W-1:0]    duty_t;
    typedef logic [MS_W-1:0]      ms_t;
    typedef logic [CURRENT_W-1:0] current_t;
    typedef logic [STATE_W-1:0]   state_code_t;
    typedef logic [CAUSE_W-1:0]   cause_t;
    typedef logic [COUNT_W-1:0]   count_t;

    localparam ms_t MS_MAX            = '1;
    localparam ms_t CLOSE_EXTRA_MS    = 20'd500;
    localparam ms_t CURRENT_IGNORE_MS = 20'd500;

    // operation codes on the input channel
    localparam logic [OP_W-1:0] OP_TICK  = 3'd0;
    localparam logic [OP_W-1:0] OP_OPEN  = 3'd1;
    localparam logic [OP_W-1:0] OP_CLOSE = 3'd2;
    localparam logic [OP_W-1:0] OP_STOP  = 3'd3;
    localparam logic [OP_W-1:0] OP_CLEAR = 3'd4;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_OPEN_BOOST_PWR  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OPEN_RUN_PWR    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CLOSE_BOOST_PWR = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CLOSE_RUN_PWR   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_OPEN_BOOST_MS   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_CLOSE_BOOST_MS  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_MOVE_TIMEOUT_MS = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_OBSTACLE_MA     = 3'd7;

    localparam duty_t    RST_OPEN_BOOST_PWR  = 8'd255;
    localparam duty_t    RST_OPEN_RUN_PWR    = 8'd128;
    localparam duty_t    RST_CLOSE_BOOST_PWR = 8'd255;
    localparam duty_t    RST_CLOSE_RUN_PWR   = 8'd128;
    localparam ms_t      RST_OPEN_BOOST_MS   = 20'd1000;
    localparam ms_t      RST_CLOSE_BOOST_MS  = 20'd1000;
    localparam ms_t      RST_MOVE_TIMEOUT_MS = 20'd30000;
    localparam current_t RST_OBSTACLE_MA     = 16'd1500;

    localparam cause_t CAUSE_NONE       = 2'd0;
    localparam cause_t CAUSE_OPEN_TO    = 2'd1;
    localparam cause_t CAUSE_CLOSE_TO   = 2'd2;
    localparam cause_t CAUSE_OBSTACLE   = 2'd3;

    localparam state_code_t DS_UNKNOWN      = 4'd0;
    localparam state_code_t DS_STOPPED      = 4'd1;
    localparam state_code_t DS_OPENING      = 4'd2;
    localparam state_code_t DS_OPENING_SLOW = 4'd3;
    localparam state_code_t DS_OPEN         = 4'd4;
    localparam state_code_t DS_CLOSING      = 4'd5;
    localparam state_code_t DS_CLOSING_SLOW = 4'd6;
    localparam state_code_t DS_OBSTACLE     = 4'd7;
    localparam state_code_t DS_TIMEOUT      = 4'd8;
    localparam state_code_t DS_ERROR        = 4'd9;
    localparam state_code_t DS_CLOSED       = 4'd10;

    typedef enum logic [2:0] {
        CMD_TICK,
        CMD_OPEN,
        CMD_CLOSE,
        CMD_STOP,
        CMD_CLEAR,
        CMD_IGNORE
    } cmd_t;

    typedef enum logic [10:0] {
        M_UNKNOWN      = 11'b000_0000_0001,
        M_STOPPED      = 11'b000_0000_0010,
        M_OPENING      = 11'b000_0000_0100,
        M_OPENING_SLOW = 11'b000_0000_1000,
        M_OPEN         = 11'b000_0001_0000,
        M_CLOSING      = 11'b000_0010_0000,
        M_CLOSING_SLOW = 11'b000_0100_0000,
        M_OBSTACLE     = 11'b000_1000_0000,
        M_TIMEOUT      = 11'b001_0000_0000,
        M_ERROR        = 11'b010_0000_0000,
        M_CLOSED       = 11'b100_0000_0000
    } mode_t;

    // one queued request after classification
    typedef struct packed {
        cmd_t     cmd;
        logic     top;
        logic     bottom;
        current_t current;
    } item_t;

    function automatic state_code_t state_code(input mode_t m);
        state_code_t c;
        unique case (m)
            M_UNKNOWN:      c = DS_UNKNOWN;
            M_STOPPED:      c = DS_STOPPED;
            M_OPENING:      c = DS_OPENING;
            M_OPENING_SLOW: c = DS_OPENING_SLOW;
            M_OPEN:         c = DS_OPEN;
            M_CLOSING:      c = DS_CLOSING;
            M_CLOSING_SLOW: c = DS_CLOSING_SLOW;
            M_OBSTACLE:     c = DS_OBSTACLE;
            M_TIMEOUT:      c = DS_TIMEOUT;
            M_ERROR:        c = DS_ERROR;
            M_CLOSED:       c = DS_CLOSED;
            default:        c = DS_UNKNOWN;
        endcase
        return c;
    endfunction

    function automatic logic is_moving(input mode_t m);
        return (m == M_OPENING) || (m == M_OPENING_SLOW) ||
               (m == M_CLOSING) || (m == M_CLOSING_SLOW);
    endfunction

endpackage

@@ rtl/motor_door_controller.sv @@
// Door motor controller, one result per request.
// s_ channel: tuser[2:0] operation (tick, open, close, stop, reset error);
// tdata holds the limit switches and the motor current.
// m_ channel: 32-bit status word with both PWM duties, door state, moving,
// error flag, obstacle count and error cause.
// cfg channel: index 0..7 selects a setting, cfg_data carries its value;
// cfg_ready is always high. Write settings only while no request is pending.
// A request accepted on s_ is written into the classifier queue, then popped into the
// state registers, which raise m_tvalid with its result; a stall on m_ keeps it queued.
// Throughput: one request per cycle while m_tready is high; the classifier queue feeds
// the executor, whose state update is a single compare-and-update step per request.
// The result stays on m_tdata until taken; while m_tready is low the queue
// keeps taking requests until it is full, then s_tready drops.
// Reset (aresetn low, synchronous): door state unknown, motor off, no error,
// counters cleared, settings back to their defaults, both channels empty.
module motor_door_controller
    import mdc_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [23:0]           s_tdata,   // top_limit, bottom_limit, motor_current_ma, pad
    input  logic [7:0]            s_tuser,   // operation, pad
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [31:0]           m_tdata,   // open_drive, close_drive, door_state, moving,
                                             // error_flag, obstacle_count, error_cause
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic        q_valid, q_ready;
    item_t       q_item;
    duty_t       open_drive, close_drive;
    state_code_t door_state;
    logic        moving, error_flag;
    count_t      obstacle_count;
    cause_t      error_cause;

    mdc_front #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_op      (s_tuser[OP_W-1:0]),
        .in_top     (s_tdata[0]),
        .in_bottom  (s_tdata[1]),
        .in_current (s_tdata[CURRENT_W+1:2]),
        .q_valid    (q_valid),
        .q_ready    (q_ready),
        .q_item     (q_item)
    );

    mdc_back u_back (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .q_valid            (q_valid),
        .q_ready            (q_ready),
        .q_item             (q_item),
        .out_valid          (m_tvalid),
        .out_ready          (m_tready),
        .out_open_drive     (open_drive),
        .out_close_drive    (close_drive),
        .out_door_state     (door_state),
        .out_moving         (moving),
        .out_error_flag     (error_flag),
        .out_obstacle_count (obstacle_count),
        .out_error_cause    (error_cause)
    );

    assign m_tdata = {error_cause, obstacle_count, error_flag, moving,
                      door_state, close_drive, open_drive};

endmodule

@@ rtl/mdc_front.sv @@
module mdc_front
    import mdc_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_valid,
    output logic            in_ready,
    input  logic [OP_W-1:0] in_op,
    input  logic            in_top,
    input  logic            in_bottom,
    input  current_t        in_current,
    output logic            q_valid,
    input  logic            q_ready,
    output item_t           q_item
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    item_t             queue_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    cmd_t              cmd;
    logic              push, pop;

    always_comb begin
        unique case (in_op)
            OP_TICK:  cmd = CMD_TICK;
            OP_OPEN:  cmd = CMD_OPEN;
            OP_CLOSE: cmd = CMD_CLOSE;
            OP_STOP:  cmd = CMD_STOP;
            OP_CLEAR: cmd = CMD_CLEAR;
            default:  cmd = CMD_IGNORE;
        endcase
    end

    assign in_ready = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign q_valid  = (count_reg != '0);
    assign q_item   = queue_reg[rd_ptr_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_valid && q_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            queue_reg[wr_ptr_reg] <= '{cmd: cmd, top: in_top, bottom: in_bottom,
                                       current: in_current};
        end
    end

endmodule

@@ rtl/mdc_back.sv @@
module mdc_back
    import mdc_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  q_valid,
    output logic                  q_ready,
    input  item_t                 q_item,
    output logic                  out_valid,
    input  logic                  out_ready,
    output duty_t                 out_open_drive,
    output duty_t                 out_close_drive,
    output state_code_t           out_door_state,
    output logic                  out_moving,
    output logic                  out_error_flag,
    output count_t                out_obstacle_count,
    output cause_t                out_error_cause
);

    duty_t    open_boost_pwr_reg, open_run_pwr_reg, close_boost_pwr_reg, close_run_pwr_reg;
    ms_t      open_boost_ms_reg, close_boost_ms_reg, move_timeout_ms_reg;
    current_t obstacle_ma_reg;

    mode_t  mode_reg, mode_next;
    logic   latch_reg, latch_next;
    count_t retries_reg, retries_next;
    ms_t    phase_ms_reg, phase_ms_next;
    ms_t    move_ms_reg, move_ms_next;
    duty_t  open_duty_reg, open_duty_next;
    duty_t  close_duty_reg, close_duty_next;
    cause_t cause_reg, cause_next;
    logic   out_valid_reg;
    logic   pop;

    assign cfg_ready = 1'b1;
    assign q_ready   = !out_valid_reg || out_ready;
    assign pop       = q_valid && q_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            open_boost_pwr_reg  <= RST_OPEN_BOOST_PWR;
            open_run_pwr_reg    <= RST_OPEN_RUN_PWR;
            close_boost_pwr_reg <= RST_CLOSE_BOOST_PWR;
            close_run_pwr_reg   <= RST_CLOSE_RUN_PWR;
            open_boost_ms_reg   <= RST_OPEN_BOOST_MS;
            close_boost_ms_reg  <= RST_CLOSE_BOOST_MS;
            move_timeout_ms_reg <= RST_MOVE_TIMEOUT_MS;
            obstacle_ma_reg     <= RST_OBSTACLE_MA;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_OPEN_BOOST_PWR:  open_boost_pwr_reg  <= cfg_data[DUTY_W-1:0];
                REG_OPEN_RUN_PWR:    open_run_pwr_reg    <= cfg_data[DUTY_W-1:0];
                REG_CLOSE_BOOST_PWR: close_boost_pwr_reg <= cfg_data[DUTY_W-1:0];
                REG_CLOSE_RUN_PWR:   close_run_pwr_reg   <= cfg_data[DUTY_W-1:0];
                REG_OPEN_BOOST_MS:   open_boost_ms_reg   <= cfg_data[MS_W-1:0];
                REG_CLOSE_BOOST_MS:  close_boost_ms_reg  <= cfg_data[MS_W-1:0];
                REG_MOVE_TIMEOUT_MS: move_timeout_ms_reg <= cfg_data[MS_W-1:0];
                REG_OBSTACLE_MA:     obstacle_ma_reg     <= cfg_data[CURRENT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        ms_t  phase_inc;
        ms_t  move_inc;
        logic blocked;

        phase_inc = (phase_ms_reg == MS_MAX) ? phase_ms_reg : phase_ms_reg + 1'b1;
        move_inc  = (move_ms_reg == MS_MAX) ? move_ms_reg : move_ms_reg + 1'b1;
        blocked   = latch_reg || is_moving(mode_reg);

        mode_next       = mode_reg;
        latch_next      = latch_reg;
        retries_next    = retries_reg;
        phase_ms_next   = phase_ms_reg;
        move_ms_next    = move_ms_reg;
        open_duty_next  = open_duty_reg;
        close_duty_next = close_duty_reg;
        cause_next      = cause_reg;

        unique case (q_item.cmd)
            CMD_TICK: begin
                phase_ms_next = phase_inc;
                move_ms_next  = move_inc;
                unique case (mode_reg)
                    M_OPENING: begin
                        if (q_item.top) begin
                            open_duty_next  = '0;
                            close_duty_next = '0;
                            mode_next       = M_OPEN;
                        end else if (phase_inc >= open_boost_ms_reg) begin
                            open_duty_next  = open_run_pwr_reg;
                            close_duty_next = '0;
                            phase_ms_next   = '0;
                            mode_next       = M_OPENING_SLOW;
                        end
                    end
                    M_OPENING_SLOW: begin
                        if (q_item.top) begin
                            open_duty_next  = '0;
                            close_duty_next = '0;
                            mode_next       = M_OPEN;
                        end else if (move_inc >= move_timeout_ms_reg) begin
                            open_duty_next  = '0;
                            close_duty_next = '0;
                            mode_next       = M_TIMEOUT;
                            latch_next      = 1'b1;
                            cause_next      = CAUSE_OPEN_TO;
                        end
                    end
                    M_CLOSING: begin
                        // bottom reached during boost keeps the boost duty
                        if (q_item.bottom) begin
                            phase_ms_next = '0;
                            mode_next     = M_CLOSING_SLOW;
                        end else if (phase_inc >= close_boost_ms_reg) begin
                            open_duty_next  = '0;
                            close_duty_next = close_run_pwr_reg;
                            phase_ms_next   = '0;
                            mode_next       = M_CLOSING_SLOW;
                        end
                    end
                    M_CLOSING_SLOW: begin
                        if (q_item.bottom) begin
                            if (phase_inc >= CLOSE_EXTRA_MS) begin
                                open_duty_next  = '0;
                                close_duty_next = '0;
                                mode_next       = M_CLOSED;
                            end
                        end else if (move_inc >= CURRENT_IGNORE_MS &&
                                     q_item.current >= obstacle_ma_reg) begin
                            retries_next    = retries_reg + 1'b1;
                            open_duty_next  = '0;
                            close_duty_next = '0;
                            mode_next       = M_OBSTACLE;
                            latch_next      = 1'b1;
                            cause_next      = CAUSE_OBSTACLE;
                        end else if (move_inc >= move_timeout_ms_reg) begin
                            open_duty_next  = '0;
                            close_duty_next = '0;
                            mode_next       = M_TIMEOUT;
                            latch_next      = 1'b1;
                            cause_next      = CAUSE_CLOSE_TO;
                        end
                    end
                    default: ;
                endcase
            end
            CMD_OPEN: begin
                if (!blocked) begin
                    if (q_item.top) begin
                        open_duty_next  = '0;
                        close_duty_next = '0;
                        mode_next       = M_OPEN;
                    end else begin
                        move_ms_next    = '0;
                        phase_ms_next   = '0;
                        open_duty_next  = open_boost_pwr_reg;
                        close_duty_next = '0;
                        mode_next       = M_OPENING;
                    end
                end
            end
            CMD_CLOSE: begin
                if (!blocked) begin
                    if (q_item.bottom) begin
                        open_duty_next  = '0;
                        close_duty_next = '0;
                        mode_next       = M_CLOSED;
                    end else begin
                        move_ms_next    = '0;
                        phase_ms_next   = '0;
                        open_duty_next  = '0;
                        close_duty_next = close_boost_pwr_reg;
                        mode_next       = M_CLOSING;
                    end
                end
            end
            CMD_STOP: begin
                open_duty_next  = '0;
                close_duty_next = '0;
                mode_next       = M_STOPPED;
            end
            CMD_CLEAR: begin
                open_duty_next  = '0;
                close_duty_next = '0;
                latch_next      = 1'b0;
                retries_next    = '0;
                cause_next      = CAUSE_NONE;
                // top wins when both switches read active
                if (q_item.top) begin
                    mode_next = M_OPEN;
                end else if (q_item.bottom) begin
                    mode_next = M_CLOSED;
                end else begin
                    mode_next = M_UNKNOWN;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg       <= M_UNKNOWN;
            latch_reg      <= 1'b0;
            retries_reg    <= '0;
            phase_ms_reg   <= '0;
            move_ms_reg    <= '0;
            open_duty_reg  <= '0;
            close_duty_reg <= '0;
            cause_reg      <= CAUSE_NONE;
            out_valid_reg  <= 1'b0;
        end else begin
            if (pop) begin
                mode_reg       <= mode_next;
                latch_reg      <= latch_next;
                retries_reg    <= retries_next;
                phase_ms_reg   <= phase_ms_next;
                move_ms_reg    <= move_ms_next;
                open_duty_reg  <= open_duty_next;
                close_duty_reg <= close_duty_next;
                cause_reg      <= cause_next;
            end
            if (pop) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result is read straight off the state registers, which only move on a pop
    assign out_valid          = out_valid_reg;
    assign out_open_drive     = open_duty_reg;
    assign out_close_drive    = close_duty_reg;
    assign out_door_state     = state_code(mode_reg);
    assign out_moving         = is_moving(mode_reg);
    assign out_error_flag     = latch_reg || (mode_reg == M_OBSTACLE) ||
                                (mode_reg == M_TIMEOUT) || (mode_reg == M_ERROR);
    assign out_obstacle_count = retries_reg;
    assign out_error_cause    = cause_reg;

endmodule

@@ rtl/mdc_checker.sv @@
module mdc_checker
    import mdc_pkg::*;
(
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [31:0]           m_tdata
);

    logic [3:0] state_f;
    logic       moving_f, error_f;

    assign state_f  = m_tdata[19:16];
    assign moving_f = m_tdata[20];
    assign error_f  = m_tdata[21];

    // no result may appear straight out of reset
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // a latched error blocks every move
    a_move_no_error: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && moving_f |-> !error_f)
        else $error("moving while an error is flagged");

    // motor is powered only while moving
    a_idle_motor_off: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !moving_f |-> m_tdata[15:0] == 16'd0)
        else $error("drive active while not moving");

    a_error_state_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (state_f == DS_OBSTACLE || state_f == DS_TIMEOUT ||
                     state_f == DS_ERROR) |-> error_f)
        else $error("error state without error flag");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

endmodule

bind motor_door_controller mdc_checker u_checker (.*);

@@ tb/testbench.sv @@
`timescale 1ns / 100ps

module testbench;
    import mdc_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASE_ITEMS = 24;
    localparam int MAX_REPORTS = 10;
    localparam int PIPE_CYCLES = 4;
    // highest operation code; the ones above OP_CLEAR do nothing
    localparam logic [OP_W-1:0] OP_TOP_CODE = 3'd7;

    typedef struct packed {
        duty_t       open_drive;
        duty_t       close_drive;
        state_code_t door_state;
        logic        moving;
        logic        error_flag;
        count_t      obstacle_count;
        cause_t      error_cause;
    } door_status_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [23:0]           s_tdata = '0;
    logic [7:0]            s_tuser = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [31:0]           m_tdata;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // settings as the controller should hold them
    duty_t    reg_open_boost = RST_OPEN_BOOST_PWR;
    duty_t    reg_open_run = RST_OPEN_RUN_PWR;
    duty_t    reg_close_boost = RST_CLOSE_BOOST_PWR;
    duty_t    reg_close_run = RST_CLOSE_RUN_PWR;
    ms_t      reg_open_boost_ms = RST_OPEN_BOOST_MS;
    ms_t      reg_close_boost_ms = RST_CLOSE_BOOST_MS;
    ms_t      reg_timeout_ms = RST_MOVE_TIMEOUT_MS;
    current_t reg_obstacle_ma = RST_OBSTACLE_MA;

    // door state as the controller should hold it
    state_code_t door = DS_UNKNOWN;
    logic        latched = 1'b0;
    count_t      obstacles = '0;
    ms_t         phase_ms = '0;
    ms_t         move_ms = '0;
    duty_t       open_duty = '0;
    duty_t       close_duty = '0;
    cause_t      cause = CAUSE_NONE;

    door_status_t status_queue[$];
    int requests_sent = 0;
    int mismatches = 0;
    int cycle_count = 0;
    int src_idle_pct = 0;
    int snk_stall_pct = 0;

    motor_door_controller uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= snk_stall_pct);
    end

    function automatic logic door_moving();
        return door inside {DS_OPENING, DS_OPENING_SLOW, DS_CLOSING, DS_CLOSING_SLOW};
    endfunction

    function automatic void motor_stop(input state_code_t next);
        open_duty = '0;
        close_duty = '0;
        door = next;
    endfunction

    function automatic void latch_fault(input state_code_t next, input cause_t why);
        motor_stop(next);
        latched = 1'b1;
        cause = why;
    endfunction

    // applies one request to the expected door state and returns the status word
    function automatic door_status_t advance_door(input logic [OP_W-1:0] op, input logic top,
            input logic bottom, input current_t amps);
        door_status_t s;
        case (op)
            OP_TICK: begin
                if (phase_ms != MS_MAX) phase_ms = phase_ms + 1'b1;
                if (move_ms != MS_MAX) move_ms = move_ms + 1'b1;
                case (door)
                    DS_OPENING: begin
                        if (top) begin
                            motor_stop(DS_OPEN);
                        end else if (phase_ms >= reg_open_boost_ms) begin
                            open_duty = reg_open_run;
                            close_duty = '0;
                            phase_ms = '0;
                            door = DS_OPENING_SLOW;
                        end
                    end
                    DS_OPENING_SLOW: begin
                        if (top) motor_stop(DS_OPEN);
                        else if (move_ms >= reg_timeout_ms) latch_fault(DS_TIMEOUT, CAUSE_OPEN_TO);
                    end
                    DS_CLOSING: begin
                        // bottom reached during boost: run on, boost duty kept
                        if (bottom) begin
                            phase_ms = '0;
                            door = DS_CLOSING_SLOW;
                        end else if (phase_ms >= reg_close_boost_ms) begin
                            open_duty = '0;
                            close_duty = reg_close_run;
                            phase_ms = '0;
                            door = DS_CLOSING_SLOW;
                        end
                    end
                    DS_CLOSING_SLOW: begin
                        if (bottom) begin
                            if (phase_ms >= CLOSE_EXTRA_MS) motor_stop(DS_CLOSED);
                        end else if (move_ms >= CURRENT_IGNORE_MS && amps >= reg_obstacle_ma) begin
                            obstacles = obstacles + 1'b1;
                            latch_fault(DS_OBSTACLE, CAUSE_OBSTACLE);
                        end else if (move_ms >= reg_timeout_ms) begin
                            latch_fault(DS_TIMEOUT, CAUSE_CLOSE_TO);
                        end
                    end
                    default: ;
                endcase
            end
            OP_OPEN: begin
                if (!latched && !door_moving()) begin
                    if (top) begin
                        motor_stop(DS_OPEN);
                    end else begin
                        move_ms = '0;
                        phase_ms = '0;
                        open_duty = reg_open_boost;
                        close_duty = '0;
                        door = DS_OPENING;
                    end
                end
            end
            OP_CLOSE: begin
                if (!latched && !door_moving()) begin
                    if (bottom) begin
                        motor_stop(DS_CLOSED);
                    end else begin
                        move_ms = '0;
                        phase_ms = '0;
                        open_duty = '0;
                        close_duty = reg_close_boost;
                        door = DS_CLOSING;
                    end
                end
            end
            OP_STOP: motor_stop(DS_STOPPED);
            OP_CLEAR: begin
                latched = 1'b0;
                obstacles = '0;
                cause = CAUSE_NONE;
                motor_stop(top ? DS_OPEN : (bottom ? DS_CLOSED : DS_UNKNOWN));
            end
            default: ;
        endcase
        s.open_drive = open_duty;
        s.close_drive = close_duty;
        s.door_state = door;
        s.moving = door_moving();
        s.error_flag = latched || (door inside {DS_OBSTACLE, DS_TIMEOUT, DS_ERROR});
        s.obstacle_count = obstacles;
        s.error_cause = cause;
        return s;
    endfunction

    always @(posedge aclk) begin
        door_status_t got;
        door_status_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.open_drive = m_tdata[7:0];
            got.close_drive = m_tdata[15:8];
            got.door_state = m_tdata[19:16];
            got.moving = m_tdata[20];
            got.error_flag = m_tdata[21];
            got.obstacle_count = m_tdata[29:22];
            got.error_cause = m_tdata[31:30];
            if (status_queue.size() == 0) begin
                if (mismatches < MAX_REPORTS) $display("unexpected status %h at %0t", m_tdata, $time);
                mismatches++;
            end else begin
                want = status_queue.pop_front();
                if (got !== want) begin
                    if (mismatches < MAX_REPORTS) begin
                        $display("status mismatch at %0t", $time);
                        $display("  expected open %0d close %0d state %0d moving %b err %b obst %0d cause %0d",
                                 want.open_drive, want.close_drive, want.door_state, want.moving,
                                 want.error_flag, want.obstacle_count, want.error_cause);
                        $display("  actual   open %0d close %0d state %0d moving %b err %b obst %0d cause %0d",
                                 got.open_drive, got.close_drive, got.door_state, got.moving,
                                 got.error_flag, got.obstacle_count, got.error_cause);
                    end
                    mismatches++;
                end
            end
        end
    end

    // valid is left high on return; settle() lowers it
    task automatic send_request(input logic [OP_W-1:0] op, input logic top, input logic bottom,
            input current_t amps);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= {5'b0, op};
        s_tdata <= {6'b0, amps, bottom, top};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        status_queue.push_back(advance_door(op, top, bottom, amps));
        requests_sent++;
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (status_queue.size() != 0) @(posedge aclk);
        repeat (PIPE_CYCLES) @(posedge aclk);
    endtask

    task automatic apply_settings(input logic [CFG_DATA_W-1:0] open_boost_pwr,
            input logic [CFG_DATA_W-1:0] open_run_pwr, input logic [CFG_DATA_W-1:0] close_boost_pwr,
            input logic [CFG_DATA_W-1:0] close_run_pwr, input logic [CFG_DATA_W-1:0] open_boost_t,
            input logic [CFG_DATA_W-1:0] close_boost_t, input logic [CFG_DATA_W-1:0] timeout_t,
            input logic [CFG_DATA_W-1:0] obstacle_ma);
        logic [CFG_DATA_W-1:0] vals [8];
        logic [CFG_IDX_W-1:0] idx;
        int i;
        vals[0] = open_boost_pwr;
        vals[1] = open_run_pwr;
        vals[2] = close_boost_pwr;
        vals[3] = close_run_pwr;
        vals[4] = open_boost_t;
        vals[5] = close_boost_t;
        vals[6] = timeout_t;
        vals[7] = obstacle_ma;
        for (i = 0; i < 8; i++) begin
            idx = i[CFG_IDX_W-1:0];
            cfg_valid <= 1'b1;
            cfg_index <= idx;
            cfg_data <= vals[i];
            @(posedge aclk);
            while (!cfg_ready) @(posedge aclk);
            case (idx)
                REG_OPEN_BOOST_PWR:  reg_open_boost = vals[i][DUTY_W-1:0];
                REG_OPEN_RUN_PWR:    reg_open_run = vals[i][DUTY_W-1:0];
                REG_CLOSE_BOOST_PWR: reg_close_boost = vals[i][DUTY_W-1:0];
                REG_CLOSE_RUN_PWR:   reg_close_run = vals[i][DUTY_W-1:0];
                REG_OPEN_BOOST_MS:   reg_open_boost_ms = vals[i][MS_W-1:0];
                REG_CLOSE_BOOST_MS:  reg_close_boost_ms = vals[i][MS_W-1:0];
                REG_MOVE_TIMEOUT_MS: reg_timeout_ms = vals[i][MS_W-1:0];
                REG_OBSTACLE_MA:     reg_obstacle_ma = vals[i][CURRENT_W-1:0];
                default: ;
            endcase
        end
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // mostly open or close moves with ticks and limit hits, some noise
    task automatic move_sequence();
        int kind;
        int ticks;
        int hit_at;
        int i;
        logic opening;
        logic preset;
        kind = $urandom_range(0, 9);
        if (kind < 2) begin
            ticks = $urandom_range(1, 6);
            for (i = 0; i < ticks; i++)
                send_request(OP_W'($urandom_range(0, OP_TOP_CODE)), 1'($urandom_range(0, 1)),
                             1'($urandom_range(0, 1)), current_t'($urandom));
        end else begin
            opening = 1'($urandom_range(0, 1));
            if (kind < 5 || (latched && $urandom_range(0, 3) != 0))
                send_request(OP_CLEAR, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                             current_t'($urandom));
            preset = ($urandom_range(0, 7) == 0);
            send_request(opening ? OP_OPEN : OP_CLOSE, opening && preset, !opening && preset,
                         current_t'($urandom));
            ticks = $urandom_range(1, 40);
            hit_at = $urandom_range(1, 60);
            for (i = 1; i <= ticks; i++)
                send_request(OP_TICK, opening && i >= hit_at, !opening && i >= hit_at,
                             current_t'($urandom));
            if ($urandom_range(0, 2) == 0)
                send_request(OP_STOP, 1'b0, 1'b0, current_t'($urandom));
        end
    endtask

    task automatic run_traffic(input int count);
        int start;
        start = requests_sent;
        while (requests_sent - start < count) move_sequence();
    endtask

    task automatic test_commands();
        int k;
        settle();
        send_request(OP_TICK, 1'b0, 1'b0, 16'h0000);
        for (k = OP_CLEAR + 1; k <= OP_TOP_CODE; k++)
            send_request(k[OP_W-1:0], 1'b1, 1'b1, 16'hFFFF);
        send_request(OP_OPEN, 1'b1, 1'b0, 16'h0000);
        send_request(OP_CLOSE, 1'b0, 1'b1, 16'h0000);
        send_request(OP_OPEN, 1'b0, 1'b0, 16'h0000);
        // both ignored while the door moves
        send_request(OP_OPEN, 1'b0, 1'b0, 16'h0000);
        send_request(OP_CLOSE, 1'b0, 1'b0, 16'h0000);
        send_request(OP_TICK, 1'b1, 1'b0, 16'h0000);
        send_request(OP_CLOSE, 1'b0, 1'b0, 16'h0000);
        send_request(OP_TICK, 1'b0, 1'b1, 16'hFFFF);
        send_request(OP_STOP, 1'b0, 1'b1, 16'h0000);
        send_request(OP_CLEAR, 1'b1, 1'b1, 16'h0000);
        send_request(OP_CLEAR, 1'b0, 1'b1, 16'h0000);
        send_request(OP_CLEAR, 1'b0, 1'b0, 16'h0000);
    endtask

    task automatic test_timeouts();
        int i;
        settle();
        // high bits above each register width must be dropped
        apply_settings(20'hFF000, 20'd255, 20'h000FF, 20'hABC00, 20'd2, 20'd0, 20'd4, 20'h0FFFF);
        send_request(OP_OPEN, 1'b0, 1'b0, 16'h0000);
        for (i = 0; i < 4; i++) send_request(OP_TICK, 1'b0, 1'b0, 16'h0000);
        send_request(OP_OPEN, 1'b0, 1'b0, 16'h0000);
        // stop keeps the latched error and its cause
        send_request(OP_STOP, 1'b0, 1'b0, 16'h0000);
        send_request(OP_CLEAR, 1'b0, 1'b0, 16'h0000);
        send_request(OP_CLOSE, 1'b0, 1'b0, 16'h0000);
        for (i = 0; i < 4; i++) send_request(OP_TICK, 1'b0, 1'b0, 16'hFFFF);
        send_request(OP_TICK, 1'b0, 1'b0, 16'h0000);
    endtask

    task automatic test_obstacle();
        int i;
        int extra;
        settle();
        src_idle_pct = 0;
        snk_stall_pct = 0;
        apply_settings(CFG_DATA_W'($urandom), CFG_DATA_W'($urandom), CFG_DATA_W'($urandom),
                       CFG_DATA_W'($urandom), CFG_DATA_W'($urandom_range(0, 5)), 20'd0,
                       20'hFFFFF, 20'h0FFFF);
        send_request(OP_CLEAR, 1'b0, 1'b0, current_t'($urandom));
        send_request(OP_CLOSE, 1'b0, 1'b0, current_t'($urandom));
        // current is ignored until the ignore window has passed
        for (i = 1; i < CURRENT_IGNORE_MS; i++)
            send_request(OP_TICK, 1'b0, 1'b0, current_t'($urandom));
        extra = $urandom_range(1, 6);
        for (i = 0; i < extra; i++)
            send_request(OP_TICK, 1'b0, 1'b0, current_t'($urandom_range(0, 16'hFFFE)));
        send_request(OP_TICK, 1'b0, 1'b0, 16'hFFFF);
        send_request(OP_STOP, 1'b0, 1'b0, current_t'($urandom));
        send_request(OP_CLOSE, 1'b0, 1'b0, current_t'($urandom));
        send_request(OP_CLEAR, 1'b0, 1'b0, current_t'($urandom));
        run_traffic(PHASE_ITEMS / 2);
    endtask

    task automatic test_random_traffic(input int src_pct, input int snk_pct,
            input logic [CFG_DATA_W-1:0] timeout_t);
        settle();
        src_idle_pct = src_pct;
        snk_stall_pct = snk_pct;
        apply_settings(CFG_DATA_W'($urandom), CFG_DATA_W'($urandom), CFG_DATA_W'($urandom),
                       CFG_DATA_W'($urandom), CFG_DATA_W'($urandom_range(0, 12)),
                       CFG_DATA_W'($urandom_range(0, 12)), timeout_t, CFG_DATA_W'($urandom));
        run_traffic(PHASE_ITEMS);
    endtask

    task automatic test_close_run_on();
        int i;
        int early;
        settle();
        src_idle_pct = 25;
        snk_stall_pct = 25;
        apply_settings(20'd255, 20'd0, 20'd0, 20'd255, 20'hFFFFF,
                       CFG_DATA_W'($urandom_range(0, 8)), 20'hFFFFF, 20'd0);
        send_request(OP_CLEAR, 1'b0, 1'b0, current_t'($urandom));
        send_request(OP_CLOSE, 1'b0, 1'b0, current_t'($urandom));
        early = $urandom_range(0, 10);
        for (i = 0; i < early; i++) send_request(OP_TICK, 1'b0, 1'b0, current_t'($urandom));
        // bottom reached: the motor runs on before the door counts as closed
        for (i = 0; i < CLOSE_EXTRA_MS + 5; i++)
            send_request(OP_TICK, 1'b0, 1'b1, current_t'($urandom));
        run_traffic(PHASE_ITEMS / 2);
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_commands();
        test_timeouts();
        test_obstacle();
        test_random_traffic(45, 0, 20'd0);
        test_random_traffic(0, 45, CFG_DATA_W'($urandom_range(3, 40)));
        test_close_run_on();
        settle();
        if (mismatches == 0 && status_queue.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/mdc_pkg.sv
rtl/mdc_front.sv
rtl/mdc_back.sv
rtl/motor_door_controller.sv
rtl/mdc_checker.sv
tb/testbench.sv
